// File: hw/rtl/utf8d_pkg.sv
// shared types and constants for the utf-8 validating decoder
// used by utf8d_front, utf8d_fifo, utf8d_back and the top level
package utf8d_pkg;

  localparam int CP_W = 21;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
  localparam logic [CP_W-1:0] MIN_CP2  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP3  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP4  = 21'h010000;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;

  // continuation counts a lead byte asks for
  localparam logic [1:0] NEED_NONE = 2'd0;
  localparam logic [1:0] NEED_ONE  = 2'd1;
  localparam logic [1:0] NEED_TWO  = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // work for one input item: n_repl replacements, then an optional tail item
  typedef struct packed {
    logic [2:0]      n_repl;
    logic            tail_valid;
    logic [CP_W-1:0] tail_cp;
    logic            tail_rep;
  } cmd_t;

endpackage

// File: hw/rtl/utf8d_front.sv
// front end: accepts bytes, tracks the open sequence and classifies each item
// depends on utf8d_pkg
module utf8d_front import utf8d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_text,
  input  logic       fifo_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [1:0]      exp_r, exp_nxt;
  logic [1:0]      held_r, held_nxt;
  logic [CP_W-1:0] part_r, part_nxt;

  logic            accept;
  logic [1:0]      lead_need;
  logic [CP_W-1:0] lead_val;
  logic            lead_open;
  logic            lead_tail_valid;
  logic [CP_W-1:0] lead_tail_cp;
  logic            lead_tail_rep;
  logic [1:0]      held_inc;
  logic [CP_W-1:0] part_ext;
  logic [CP_W-1:0] min_cp;
  logic            complete;
  logic            bad_val;
  cmd_t            cmd;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  // lead byte decode
  always_comb begin
    lead_need = NEED_NONE;
    lead_val  = '0;
    if (in_data_byte[7:5] == 3'b110) begin
      lead_need = NEED_ONE;
      lead_val  = {16'd0, in_data_byte[4:0]};
    end else if (in_data_byte[7:4] == 4'b1110) begin
      lead_need = NEED_TWO;
      lead_val  = {17'd0, in_data_byte[3:0]};
    end else if (in_data_byte[7:3] == 5'b11110) begin
      lead_need = NEED_THREE;
      lead_val  = {18'd0, in_data_byte[2:0]};
    end
    lead_open       = (lead_need != NEED_NONE) && !in_end_of_text;
    lead_tail_valid = !lead_open;
    if (!in_data_byte[7]) begin
      lead_tail_cp  = {13'd0, in_data_byte};
      lead_tail_rep = 1'b0;
    end else begin
      lead_tail_cp  = REPL_CP;
      lead_tail_rep = 1'b1;
    end
  end

  // continuation path
  assign held_inc = held_r + 2'd1;
  assign part_ext = {part_r[CP_W-7:0], in_data_byte[5:0]};
  assign complete = held_inc >= exp_r;

  always_comb begin
    case (exp_r)
      NEED_ONE: min_cp = MIN_CP2;
      NEED_TWO: min_cp = MIN_CP3;
      default:  min_cp = MIN_CP4;
    endcase
    bad_val = (part_ext < min_cp) || (part_ext > MAX_CP) ||
              ((part_ext >= SURR_LO) && (part_ext <= SURR_HI));
  end

  always_comb begin
    cmd.n_repl     = 3'd0;
    cmd.tail_valid = 1'b0;
    cmd.tail_cp    = lead_tail_cp;
    cmd.tail_rep   = lead_tail_rep;
    exp_nxt        = NEED_NONE;
    held_nxt       = 2'd0;
    part_nxt       = '0;
    if ((exp_r == NEED_NONE) || (in_data_byte[7:6] != 2'b10)) begin
      // fresh lead, possibly after a broken sequence
      if (exp_r != NEED_NONE) begin
        cmd.n_repl = 3'd1 + {1'b0, held_r};
      end
      cmd.tail_valid = lead_tail_valid;
      if (lead_open) begin
        exp_nxt  = lead_need;
        part_nxt = lead_val;
      end
    end else if (complete) begin
      if (bad_val) begin
        cmd.n_repl = 3'd1 + {1'b0, held_inc};
      end else begin
        cmd.tail_valid = 1'b1;
        cmd.tail_cp    = part_ext;
        cmd.tail_rep   = 1'b0;
      end
    end else if (in_end_of_text) begin
      cmd.n_repl = 3'd1 + {1'b0, held_inc};
    end else begin
      exp_nxt  = exp_r;
      held_nxt = held_inc;
      part_nxt = part_ext;
    end
  end

  assign push     = accept && ((cmd.n_repl != 3'd0) || cmd.tail_valid);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= NEED_NONE;
      held_r <= 2'd0;
      part_r <= '0;
    end else if (accept) begin
      exp_r  <= exp_nxt;
      held_r <= held_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

// File: hw/rtl/utf8d_fifo.sv
// small command queue between the front end and the back end
// depends on utf8d_pkg
module utf8d_fifo import utf8d_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == FULL_CNT;
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/utf8d_back.sv
// back end: expands each queued command into result items, one per cycle while out_ready allows
// depends on utf8d_pkg
module utf8d_back import utf8d_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_was_replaced,
  output logic            out_run_last
);

  logic [1:0]      idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] cp_r;
  logic            rep_r;
  logic            last_r;

  logic            load;
  logic [2:0]      total;
  logic            is_last;
  logic [CP_W-1:0] item_cp;
  logic            item_rep;

  assign load    = !empty && (!out_valid_r || out_ready);
  assign total   = head.n_repl + {2'd0, head.tail_valid};
  assign is_last = ({1'b0, idx_r} + 3'd1) == total;
  assign pop     = load && is_last;

  always_comb begin
    if ({1'b0, idx_r} < head.n_repl) begin
      item_cp  = REPL_CP;
      item_rep = 1'b1;
    end else begin
      item_cp  = head.tail_cp;
      item_rep = head.tail_rep;
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= item_cp;
      rep_r  <= item_rep;
      last_r <= is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = cp_r;
  assign out_was_replaced = rep_r;
  assign out_run_last     = last_r;

endmodule

// File: hw/rtl/utf8_validating_decoder.sv
// utf-8 validating decoder, top level: front end, command queue, back end
// a result of a byte goes through the command queue, then the output register
// throughput: one byte per cycle while the queue has room; the back end gives
//   one result per cycle while out_ready is high, and the queue absorbs runs
// reset: synchronous active-low rst_n clears the open sequence, queue and output
// depends on utf8d_pkg, utf8d_front, utf8d_fifo, utf8d_back
module utf8_validating_decoder import utf8d_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            in_end_of_text,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_was_replaced,
  output logic            out_run_last
);

  // queue handshake between the two halves
  logic fifo_push;
  logic fifo_pop;
  logic fifo_full;
  logic fifo_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // front end: sequence state lives here, each item becomes one command
  // (bytes that only extend a sequence push nothing)
  utf8d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_end_of_text (in_end_of_text),
    .fifo_full      (fifo_full),
    .push           (fifo_push),
    .push_cmd       (push_cmd)
  );

  // short queue so an error run in the back end stalls the input only once full
  utf8d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .pop      (fifo_pop),
    .head     (head_cmd),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  // back end: replacements first, then the tail item, into the output register
  utf8d_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head_cmd),
    .empty            (fifo_empty),
    .pop              (fifo_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_was_replaced (out_was_replaced),
    .out_run_last     (out_run_last)
  );

  // a replaced item always carries the replacement character
  a_repl_cp : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_replaced |-> out_code_point == REPL_CP)
    else $error("replaced item without replacement character");

  // a decoded item is a scalar value: in range and not a surrogate
  a_scalar : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_replaced |->
      (out_code_point <= MAX_CP) &&
      !((out_code_point >= SURR_LO) && (out_code_point <= SURR_HI)))
    else $error("decoded item is not a scalar value");

  // retiring a command means its last item was just loaded
  a_pop_last : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |=> out_valid && out_run_last)
    else $error("command retired without its last item");

  // the queue never takes a command while full
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_full |-> !fifo_push)
    else $error("push into full queue");

endmodule

// File: test/tb.sv
// self-checking testbench for utf8_validating_decoder: byte items in, code point items out
// depends on utf8d_pkg for the code point width and the utf-8 limits
`timescale 1ns / 100ps

module tb;
  import utf8d_pkg::*;

  // one decoded code point as it leaves the block
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            repl;
    logic            run_last;
  } cp_item_t;

  // utf-8 decoder predictor plus the queue of code points still owed by the block
  class cp_scoreboard;
    logic [1:0]      open_need;
    logic [1:0]      held_cnt;
    logic [CP_W-1:0] acc_value;
    cp_item_t        step_cps[$];
    cp_item_t        expected_cps[$];
    int              errors;

    function new();
      open_need = NEED_NONE;
      held_cnt  = 2'd0;
      acc_value = '0;
      errors    = 0;
    endfunction

    function void push_cp(logic [CP_W-1:0] cp, logic repl);
      cp_item_t item;
      item.cp       = cp;
      item.repl     = repl;
      item.run_last = 1'b0;
      if (step_cps.size() < 4) step_cps.push_back(item);
    endfunction

    function void close_seq();
      open_need = NEED_NONE;
      held_cnt  = 2'd0;
      acc_value = '0;
    endfunction

    // one replacement for the lead and one per continuation held
    function void fail_run();
      for (int i = 0; i <= held_cnt; i++) push_cp(REPL_CP, 1'b1);
      close_seq();
    endfunction

    function void take_lead(logic [7:0] b, logic eot);
      logic [1:0]      need;
      logic [CP_W-1:0] value;
      if (b < 8'h80) begin
        push_cp({13'd0, b}, 1'b0);
        return;
      end
      if (b[7:5] == 3'b110) begin
        need  = NEED_ONE;
        value = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        need  = NEED_TWO;
        value = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        need  = NEED_THREE;
        value = {18'd0, b[2:0]};
      end else begin
        push_cp(REPL_CP, 1'b1);
        return;
      end
      if (eot) begin
        push_cp(REPL_CP, 1'b1);
        return;
      end
      open_need = need;
      held_cnt  = 2'd0;
      acc_value = value;
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
      logic [CP_W-1:0] min_cp;
      step_cps.delete();
      if (open_need == NEED_NONE) begin
        take_lead(b, eot);
      end else if (b[7:6] != 2'b10) begin
        fail_run();
        take_lead(b, eot);
      end else begin
        acc_value = {acc_value[CP_W-7:0], b[5:0]};
        held_cnt  = held_cnt + 2'd1;
        if (held_cnt >= open_need) begin
          min_cp = (open_need == NEED_ONE) ? MIN_CP2 :
                   (open_need == NEED_TWO) ? MIN_CP3 : MIN_CP4;
          if (acc_value < min_cp || acc_value > MAX_CP ||
              (acc_value >= SURR_LO && acc_value <= SURR_HI)) begin
            fail_run();
          end else begin
            push_cp(acc_value, 1'b0);
            close_seq();
          end
        end else if (eot) begin
          fail_run();
        end
      end
      if (step_cps.size() > 0) step_cps[step_cps.size()-1].run_last = 1'b1;
      foreach (step_cps[i]) expected_cps.push_back(step_cps[i]);
    endfunction

    function void check_cp(logic [CP_W-1:0] cp, logic repl, logic run_last);
      cp_item_t want;
      if (expected_cps.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual cp %h repl %b last %b",
                 $time, cp, repl, run_last);
        errors++;
        return;
      end
      want = expected_cps.pop_front();
      if (cp !== want.cp) begin
        $display("%0t: code_point mismatch: expected %h, actual %h", $time, want.cp, cp);
        errors++;
      end
      if (repl !== want.repl) begin
        $display("%0t: was_replaced mismatch: expected %b, actual %b",
                 $time, want.repl, repl);
        errors++;
      end
      if (run_last !== want.run_last) begin
        $display("%0t: run_last mismatch: expected %b, actual %b",
                 $time, want.run_last, run_last);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_data_byte;
  logic            in_end_of_text;
  logic            out_valid;
  logic            out_ready;
  logic [CP_W-1:0] out_code_point;
  logic            out_was_replaced;
  logic            out_run_last;

  cp_scoreboard cp_sb;

  // random idling switches for the byte source and the result sink
  bit src_idle;
  bit sink_idle;
  int stall_left;

  utf8_validating_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_was_replaced (out_was_replaced),
    .out_run_last     (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous overall limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // sink side: random stall bursts while sink idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one process notes accepted bytes before checking results, so the order is fixed
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) cp_sb.note_byte(in_data_byte, in_end_of_text);
      if (out_valid && out_ready)
        cp_sb.check_cp(out_code_point, out_was_replaced, out_run_last);
    end
  end

  // present one byte item and hold it until the handshake at a clock edge
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
  endtask

  // random text: mostly well-formed sequences, with noise, bad values and broken runs
  task automatic send_random_text(input int n_bytes);
    logic [7:0]      seq[$];
    logic [7:0]      lead;
    logic [CP_W-1:0] cp;
    int              sent;
    int              kind;
    int              len;
    int              cut;
    logic            eot;
    sent = 0;
    while (sent < n_bytes) begin
      seq.delete();
      kind = $urandom_range(0, 11);
      len  = $urandom_range(1, 4);
      if (kind == 0) begin
        seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        case (len)
          1:       cp = 21'($urandom_range(0, 'h7F));
          2:       cp = 21'($urandom_range('h80, 'h7FF));
          3:       cp = 21'($urandom_range('h800, 'hFFFF));
          default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        // any value that fits the length: overlong and above the top code point
        if (kind == 1) cp = 21'($urandom_range(0, (1 << (len == 1 ? 7 : 5 * len + 1)) - 1));
        // surrogate halves
        if (kind == 2) begin
          len = 3;
          cp  = 21'($urandom_range('hD800, 'hDFFF));
        end
        if (len == 1) begin
          seq.push_back(cp[7:0]);
        end else begin
          lead = 8'(cp >> (6 * (len - 1)));
          case (len)
            2:       lead = lead | 8'hC0;
            3:       lead = lead | 8'hE0;
            default: lead = lead | 8'hF0;
          endcase
          seq.push_back(lead);
          for (int k = len - 2; k >= 0; k--) seq.push_back(8'h80 | 8'((cp >> (6 * k)) & 'h3F));
        end
        // cut the sequence short
        if (kind == 3 && len > 1) begin
          cut = $urandom_range(1, len - 1);
          repeat (cut) void'(seq.pop_back());
        end
        // break a continuation
        if (kind == 4 && len > 1) seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      end
      foreach (seq[i]) begin
        eot = (i == seq.size() - 1 && $urandom_range(0, 7) == 0) ||
              $urandom_range(0, 39) == 0;
        send_byte(seq[i], eot);
        sent++;
      end
    end
  endtask

  // directed bytes as {end_of_text, data_byte}
  logic [8:0] directed_bytes[] = '{
    9'h000,                          // lowest ascii
    9'h17F,                          // highest ascii, flagged final
    9'h080,                          // stray continuation
    9'h0C2, 9'h0A9,                  // two-byte sequence
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // largest scalar value
    9'h0C1, 9'h0BF,                  // overlong two-byte
    9'h0ED, 9'h0A0, 9'h080,          // surrogate
    9'h0F4, 9'h090, 9'h080, 9'h080,  // above the top code point
    9'h0E2, 9'h082, 9'h041,          // bad continuation, then ascii
    9'h0F0, 9'h09F, 9'h098, 9'h0FF,  // lead and two held, then an invalid lead: four results
    9'h1C3,                          // multi-byte lead flagged final
    9'h0E2, 9'h182                   // cut off inside the sequence
  };

  initial begin
    cp_sb          = new();
    src_idle       = 1'b1;
    sink_idle      = 1'b1;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_end_of_text = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

    // source holds off until the block has delivered everything owed
    in_valid <= 1'b0;
    @(posedge clk);
    while (cp_sb.expected_cps.size() != 0) @(posedge clk);

    send_random_text(50);

    // closing stretch at full rate on both sides
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_random_text(20);
    in_valid <= 1'b0;
    @(posedge clk);

    while (cp_sb.expected_cps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (cp_sb.errors == 0 && cp_sb.expected_cps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
